// ===== sv/sor_linear_solver_core_macros.svh =====
// Assertion macros for the SOR solver core. Each macro expects clk and arst_n in scope.
`ifndef SOR_LINEAR_SOLVER_CORE_MACROS_SVH
`define SOR_LINEAR_SOLVER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SOR_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error("sor assertion failed");
`define SOR_ASSERT_NXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error("sor assertion failed");
`else
`define SOR_ASSERT_IMP(lbl, ante, cons)
`define SOR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== sv/sor_pkg.sv =====
package sor_pkg;

	localparam logic [1:0] ACT_LOAD_A = 2'd0;
	localparam logic [1:0] ACT_LOAD_B = 2'd1;
	localparam logic [1:0] ACT_LOAD_X = 2'd2;
	localparam logic [1:0] ACT_START  = 2'd3;

	localparam logic [1:0] REG_SIZE  = 2'd0;
	localparam logic [1:0] REG_TOL   = 2'd1;
	localparam logic [1:0] REG_RELAX = 2'd2;
	localparam logic [1:0] REG_LIMIT = 2'd3;

	localparam logic [1:0] ST_CONVERGED = 2'd0;
	localparam logic [1:0] ST_ZERO_DIAG = 2'd1;
	localparam logic [1:0] ST_LIMIT     = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ISSUE,
		S_DRAIN,
		S_NUM,
		S_DIV,
		S_RLXMUL,
		S_RLXWR,
		S_SQ,
		S_CHECK,
		S_OUT
	} state_t;

	typedef struct packed {
		logic shift;
		logic wr;
		logic wrap;
	} cell_ctl_t;

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s[64] != s[63]) begin
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) - 65'(b);
		if (s[64] != s[63]) begin
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end
		return s[63:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			return 32'sh7FFF_FFFF;
		end
		if (v < -64'sh0000_0000_8000_0000) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

endpackage

// ===== sv/sor_x_cell.sv =====
// One entry of the solution vector, held in a ring that rotates toward cell zero.
module sor_x_cell (
	input  logic                  clk,
	input  sor_pkg::cell_ctl_t    ctl,
	input  logic signed [31:0]    wr_data,
	input  logic signed [31:0]    nb_data,
	input  logic signed [31:0]    head_data,
	output logic signed [31:0]    x
);

	logic signed [31:0] x_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			x_q <= wr_data;
		end else if (ctl.shift) begin
			x_q <= ctl.wrap ? head_data : nb_data;
		end
	end

	assign x = x_q;

endmodule

// ===== sv/sor_div.sv =====
// Restoring divider, one quotient bit per cycle, on magnitudes.
module sor_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [63:0]  num,
	input  logic signed [31:0]  den,
	output logic                done,
	output logic [63:0]         q_mag,
	output logic                neg
);

	logic [63:0] dvd_q;
	logic [31:0] den_q;
	logic [31:0] rem_q;
	logic [6:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic        neg_q;
	logic [32:0] trial;
	logic        fits;

	assign trial = {rem_q, dvd_q[63]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= num[63] ? 64'(-num) : 64'(num);
			den_q <= den[31] ? 32'(-den) : 32'(den);
			rem_q <= '0;
			neg_q <= num[63] ^ den[31];
		end else if (run_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			dvd_q <= {dvd_q[62:0], fits};
		end
	end

	assign done  = done_q;
	assign q_mag = dvd_q;
	assign neg   = neg_q;

endmodule

// ===== sv/sor_linear_solver_core.sv =====
// SOR linear solver core. Load words (matrix entry, right-hand entry, initial guess entry)
// are taken one per cycle while busy is low; a start word then runs relaxation sweeps
// until the sum of squared residuals is within tolerance squared, a diagonal entry is
// zero, or the sweep limit is reached. Each result word appears on the result ports for
// exactly one cycle with done high, one word per cycle for n consecutive cycles, and the
// receiver cannot stall them, so it must take every word as it comes. An update row reads
// its n matrix entries through the single read port of the coefficient memory, drains the
// multiply-accumulate pipeline, forms the numerator, runs the bit-serial divider, and
// relaxes and writes the entry back; a residual row reads and accumulates its entries,
// then squares the residual. Each sweep ends with a check, and the result words follow
// the last sweep. A zero diagonal ends the solve at the row where it is met.
module sor_linear_solver_core #(
	parameter int MAX_N     = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic [3:0]         row,
	input  logic [3:0]         col,
	input  logic signed [31:0] value,
	input  logic               wr_en,
	input  logic [1:0]         reg_index,
	input  logic [30:0]        wr_data,
	output logic               done,
	output logic [3:0]         index,
	output logic signed [31:0] solution,
	output logic [15:0]        sweeps,
	output logic [1:0]         status,
	output logic               last
);

`include "sor_linear_solver_core_macros.svh"

	// Largest system order actually used, and the widths that follow from it.
	localparam int CAP = (MAX_N < 16) ? MAX_N : 16;
	localparam int CW  = $clog2(CAP + 1);
	localparam int IW  = $clog2(MAX_N);
	localparam int AW  = $clog2(MAX_N * MAX_N);

	// Configuration registers.
	logic [4:0]  size_q;
	logic [30:0] tol_q;
	logic [17:0] relax_q;
	logic [15:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= 5'd16;
			tol_q   <= 31'd66;
			relax_q <= 18'd65536;
			limit_q <= 16'd1000;
		end else if (wr_en) begin
			unique case (reg_index)
				sor_pkg::REG_SIZE:  size_q  <= wr_data[4:0];
				sor_pkg::REG_TOL:   tol_q   <= wr_data;
				sor_pkg::REG_RELAX: relax_q <= wr_data[17:0];
				sor_pkg::REG_LIMIT: limit_q <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	sor_pkg::state_t st_q, st_d;

	logic accept, load_a, load_b, load_x, go;
	logic row_ok, col_ok;

	assign accept = start && !busy;
	assign go     = accept && (action == sor_pkg::ACT_START);
	assign row_ok = int'(row) < MAX_N;
	assign col_ok = int'(col) < MAX_N;
	assign load_a = accept && (action == sor_pkg::ACT_LOAD_A) && row_ok && col_ok;
	assign load_b = accept && (action == sor_pkg::ACT_LOAD_B) && row_ok;
	assign load_x = accept && (action == sor_pkg::ACT_LOAD_X) && row_ok;

	// Solve control registers.
	logic [CW-1:0] n_q, i_q, jr_q, out_q;
	logic          upd_q;
	logic [15:0]   sweep_q;
	logic [1:0]    status_q;
	logic [61:0]   tol2_q;
	logic [63:0]   norm_q;

	logic [CW-1:0] n_w;
	logic [15:0]   limit_w;
	logic          row_end, issue_end, out_end, pipe_empty;
	logic          div_done;

	assign n_w = (size_q == 5'd0) ? CW'(1) :
		(int'(size_q) > CAP) ? CW'(CAP) : CW'(size_q);
	assign limit_w   = (limit_q == 16'd0) ? 16'd1 : limit_q;
	assign row_end   = (i_q == n_q - CW'(1));
	assign issue_end = (jr_q == n_q - CW'(1));
	assign out_end   = (out_q == n_q - CW'(1));

	// Coefficient memory with registered read.
	logic signed [31:0] a_mem [MAX_N * MAX_N];
	logic signed [31:0] a_rd_q;
	logic [AW-1:0]      a_wr_addr, a_rd_addr;

	assign a_wr_addr = AW'(MAX_N * int'(row) + int'(col));
	assign a_rd_addr = AW'(MAX_N * int'(i_q) + int'(jr_q));

	always_ff @(posedge clk) begin
		if (load_a) begin
			a_mem[a_wr_addr] <= value;
		end
		a_rd_q <= a_mem[a_rd_addr];
	end

	// Right-hand memory, read at the current row every cycle.
	logic signed [31:0] b_mem [MAX_N];
	logic signed [31:0] b_rd_q;

	always_ff @(posedge clk) begin
		if (load_b) begin
			b_mem[IW'(row)] <= value;
		end
		b_rd_q <= b_mem[IW'(i_q)];
	end

	// Solution ring: cell zero always holds the entry that the datapath needs next.
	// Only the cells below the order in use rotate; the others keep their entries.
	logic signed [31:0] x_w [MAX_N];
	logic signed [31:0] head;
	logic signed [31:0] x_wr_data;
	logic signed [31:0] nx_w;
	logic               ring_shift;
	logic               rd_v_s1;

	assign head       = x_w[0];
	assign ring_shift = rd_v_s1 || (st_q == sor_pkg::S_OUT);
	assign x_wr_data  = (st_q == sor_pkg::S_IDLE) ? value : nx_w;

	for (genvar k = 0; k < MAX_N; k++) begin : g_cell
		sor_pkg::cell_ctl_t ctl;
		assign ctl.shift = ring_shift && (k < int'(n_q));
		assign ctl.wrap  = (k == int'(n_q) - 1);
		assign ctl.wr    = (load_x && (int'(row) == k)) ||
			((st_q == sor_pkg::S_RLXWR) && (int'(i_q) == k));
		sor_x_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.wr_data   (x_wr_data),
			.nb_data   (x_w[(k + 1) % MAX_N]),
			.head_data (head),
			.x         (x_w[k])
		);
	end

	// Multiply-accumulate pipeline over one matrix row.
	logic [CW-1:0]      rd_j_s1;
	logic signed [63:0] prod_s2;
	logic               mv_s2, skip_s2;
	logic signed [63:0] acc_q;
	logic signed [31:0] diag_q, xi_q;
	logic               row_start;

	assign pipe_empty = !rd_v_s1 && !mv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			mv_s2   <= 1'b0;
		end else begin
			rd_v_s1 <= (st_q == sor_pkg::S_ISSUE);
			mv_s2   <= rd_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		rd_j_s1 <= jr_q;
		prod_s2 <= a_rd_q * head;
		skip_s2 <= upd_q && (rd_j_s1 == i_q);
		if (rd_v_s1 && upd_q && (rd_j_s1 == i_q)) begin
			diag_q <= a_rd_q;
			xi_q   <= head;
		end
		if (row_start) begin
			acc_q <= '0;
		end else if (mv_s2 && !skip_s2) begin
			acc_q <= sor_pkg::sat_add64(acc_q, prod_s2);
		end
	end

	// Row numerator, divide, relax and residual datapath.
	logic signed [63:0]  num_q;
	logic signed [31:0]  q32_q;
	logic signed [51:0]  rp_q;
	logic [63:0]         sq_q;
	logic [63:0]         q_mag;
	logic                q_neg;
	logic signed [31:0]  q_sat;
	logic signed [31:0]  r_w;
	logic signed [63:0]  sq_w;
	logic signed [32:0]  diff_w;
	logic signed [51:0]  rp_w;
	logic [64:0]         norm_sum;
	logic                div_start;

	assign r_w    = sor_pkg::sat32(num_q >>> FRAC_BITS);
	assign sq_w   = r_w * r_w;
	assign diff_w = 33'(q32_q) - 33'(xi_q);
	assign rp_w   = diff_w * $signed({1'b0, relax_q});
	assign nx_w   = sor_pkg::sat32(64'(rp_q >>> FRAC_BITS) + 64'(xi_q));
	assign norm_sum = 65'(norm_q) + 65'(sq_q);

	always_comb begin
		if (!q_neg) begin
			q_sat = (q_mag > 64'h0000_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : q_mag[31:0];
		end else begin
			q_sat = (q_mag > 64'h0000_0000_8000_0000) ? 32'sh8000_0000 :
				32'(-q_mag[31:0]);
		end
	end

	sor_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (diag_q),
		.done   (div_done),
		.q_mag  (q_mag),
		.neg    (q_neg)
	);

	// Next state.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			sor_pkg::S_IDLE:   if (go) st_d = sor_pkg::S_ISSUE;
			sor_pkg::S_ISSUE:  if (issue_end) st_d = sor_pkg::S_DRAIN;
			sor_pkg::S_DRAIN:  if (pipe_empty) st_d = sor_pkg::S_NUM;
			sor_pkg::S_NUM: begin
				if (!upd_q) begin
					st_d = sor_pkg::S_SQ;
				end else if (diag_q == 32'sd0) begin
					st_d = sor_pkg::S_OUT;
				end else begin
					st_d = sor_pkg::S_DIV;
				end
			end
			sor_pkg::S_DIV:    if (div_done) st_d = sor_pkg::S_RLXMUL;
			sor_pkg::S_RLXMUL: st_d = sor_pkg::S_RLXWR;
			sor_pkg::S_RLXWR:  st_d = sor_pkg::S_ISSUE;
			sor_pkg::S_SQ:     st_d = row_end ? sor_pkg::S_CHECK : sor_pkg::S_ISSUE;
			sor_pkg::S_CHECK: begin
				if ((norm_q <= 64'(tol2_q)) || (sweep_q >= limit_w)) begin
					st_d = sor_pkg::S_OUT;
				end else begin
					st_d = sor_pkg::S_ISSUE;
				end
			end
			sor_pkg::S_OUT:    if (out_end) st_d = sor_pkg::S_IDLE;
			default:           st_d = sor_pkg::S_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		busy      = 1'b1;
		div_start = 1'b0;
		row_start = 1'b0;
		unique case (st_q)
			sor_pkg::S_IDLE: begin
				busy      = 1'b0;
				row_start = go;
			end
			sor_pkg::S_NUM:    div_start = upd_q && (diag_q != 32'sd0);
			sor_pkg::S_RLXWR:  row_start = 1'b1;
			sor_pkg::S_SQ:     row_start = 1'b1;
			sor_pkg::S_CHECK:  row_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= sor_pkg::S_IDLE;
			sweep_q  <= '0;
			status_q <= sor_pkg::ST_CONVERGED;
			n_q      <= CW'(CAP);
			i_q      <= '0;
			jr_q     <= '0;
			out_q    <= '0;
			upd_q    <= 1'b1;
		end else begin
			st_q <= st_d;
			if (row_start) begin
				jr_q <= '0;
			end else if (st_q == sor_pkg::S_ISSUE) begin
				jr_q <= jr_q + CW'(1);
			end
			unique case (st_q)
				sor_pkg::S_IDLE: begin
					if (go) begin
						n_q     <= n_w;
						i_q     <= '0;
						upd_q   <= 1'b1;
						sweep_q <= 16'd1;
					end
				end
				sor_pkg::S_NUM: begin
					if (upd_q && (diag_q == 32'sd0)) begin
						status_q <= sor_pkg::ST_ZERO_DIAG;
						out_q    <= '0;
					end
				end
				sor_pkg::S_RLXWR: begin
					i_q <= row_end ? '0 : i_q + CW'(1);
					if (row_end) begin
						upd_q <= 1'b0;
					end
				end
				sor_pkg::S_SQ: begin
					if (!row_end) begin
						i_q <= i_q + CW'(1);
					end
				end
				sor_pkg::S_CHECK: begin
					out_q <= '0;
					i_q   <= '0;
					if (norm_q <= 64'(tol2_q)) begin
						status_q <= sor_pkg::ST_CONVERGED;
					end else if (sweep_q >= limit_w) begin
						status_q <= sor_pkg::ST_LIMIT;
					end else begin
						upd_q   <= 1'b1;
						sweep_q <= sweep_q + 16'd1;
					end
				end
				sor_pkg::S_OUT:    out_q <= out_q + CW'(1);
				default: ;
			endcase
		end
	end

	// Datapath registers that need no reset.
	always_ff @(posedge clk) begin
		if (go) begin
			tol2_q <= tol_q * tol_q;
		end
		if (go || (st_q == sor_pkg::S_RLXWR && row_end)) begin
			norm_q <= '0;
		end else if (st_q == sor_pkg::S_SQ) begin
			norm_q <= norm_sum[64] ? {64{1'b1}} : norm_sum[63:0];
		end
		if (st_q == sor_pkg::S_DRAIN) begin
			num_q <= sor_pkg::sat_sub64(64'(b_rd_q) <<< FRAC_BITS, acc_q);
		end
		if (st_q == sor_pkg::S_NUM) begin
			sq_q <= 64'(sq_w);
		end
		if (div_done) begin
			q32_q <= q_sat;
		end
		if (st_q == sor_pkg::S_RLXMUL) begin
			rp_q <= rp_w;
		end
	end

	// Result words, one per cycle while the ring rotates out.
	logic               done_q, last_q;
	logic [3:0]         index_q;
	logic signed [31:0] sol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			done_q <= (st_q == sor_pkg::S_OUT);
			last_q <= (st_q == sor_pkg::S_OUT) && out_end;
		end
	end

	always_ff @(posedge clk) begin
		index_q <= 4'(out_q);
		sol_q   <= head;
	end

	assign done     = done_q;
	assign last     = last_q;
	assign index    = index_q;
	assign solution = sol_q;
	assign sweeps   = sweep_q;
	assign status   = status_q;

	// A result word only follows a cycle of the output state.
	`SOR_ASSERT_IMP(a_done_from_out, done, $past(st_q == sor_pkg::S_OUT))
	// The last marker never shows without its strobe.
	`SOR_ASSERT_IMP(a_last_has_done, last, done)
	// A start word always makes the block busy in the next cycle.
	`SOR_ASSERT_NXT(a_start_busy, go, busy)
	// Matrix reads never run past the order in use.
	`SOR_ASSERT_IMP(a_issue_range, st_q == sor_pkg::S_ISSUE, jr_q < n_q)
	// The ring is only written while it is aligned.
	`SOR_ASSERT_IMP(a_wr_aligned, st_q == sor_pkg::S_RLXWR, pipe_empty)

endmodule
